// ===== hw/rtl/x86d_pkg.sv =====
package x86d_pkg;

  localparam int AddrBits = 16;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_OPCODE  = 3'd1,
    PH_MODRM   = 3'd2,
    PH_DISP_LO = 3'd3,
    PH_DISP_HI = 3'd4,
    PH_IMM_LO  = 3'd5,
    PH_IMM_HI  = 3'd6
  } phase_t;

  localparam logic [7:0] OP_REPNE = 8'hF2;
  localparam logic [7:0] OP_REPE  = 8'hF3;
  localparam logic [7:0] OP_LEA   = 8'h8D;

  // Collected instruction handed from the collector to the decode stage.
  typedef struct packed {
    logic [15:0] start_addr;
    logic [2:0]  length;
    logic [1:0]  prefix_kind;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] imm;
    logic        trunc;
  } raw_instr_t;

  typedef struct packed {
    logic [15:0] start_addr;
    logic [2:0]  length;
    logic [5:0]  operation;
    logic [1:0]  prefix_kind;
    logic [2:0]  operand_form;
    logic        wide;
    logic [2:0]  reg_field;
    logic [7:0]  modrm_byte;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [15:0] branch_target;
    logic        status;
  } dec_instr_t;

  function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                  input logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic alu_pair(input logic [7:0] op);
    return (op <= 8'h3F) && !op[2];
  endfunction

  function automatic logic wants_modrm(input logic [7:0] op);
    return alu_pair(op) || in_rng(op, 8'h80, 8'h8B) || op == OP_LEA || op == 8'hC6 ||
           op == 8'hC7 || op == 8'hD1 || op == 8'hD3 || op == 8'hF6 || op == 8'hF7 ||
           op == 8'hFF;
  endfunction

  function automatic logic is_relative(input logic [7:0] op);
    return in_rng(op, 8'h70, 8'h7F) || op == 8'hE2 || op == 8'hE8 || op == 8'hE9 ||
           op == 8'hEB;
  endfunction

  function automatic logic [1:0] disp_len(input logic [7:0] op, input logic [7:0] m);
    logic [1:0] r;
    r = 2'd0;
    if (wants_modrm(op)) begin
      if (m[7:6] == 2'd0 && m[2:0] == 3'd6) r = 2'd2;
      else if (m[7:6] == 2'd1) r = 2'd1;
      else if (m[7:6] == 2'd2) r = 2'd2;
    end else if (in_rng(op, 8'h70, 8'h7F) || op == 8'hE2 || op == 8'hEB) begin
      r = 2'd1;
    end else if (op == 8'hE8 || op == 8'hE9 || op == 8'hA3) begin
      r = 2'd2;
    end
    return r;
  endfunction

  function automatic logic [1:0] imm_len(input logic [7:0] op, input logic [7:0] m);
    logic [1:0] r;
    r = 2'd0;
    if (op == 8'h80 || op == 8'h82 || op == 8'h83 || op == 8'hC6) r = 2'd1;
    else if (op == 8'h81 || op == 8'hC7) r = 2'd2;
    else if (in_rng(op, 8'hB0, 8'hBF)) r = op[3] ? 2'd2 : 2'd1;
    else if (op == 8'hF6) r = (m[5:3] < 3'd2) ? 2'd1 : 2'd0;
    else if (op == 8'hF7) r = (m[5:3] < 3'd2) ? 2'd2 : 2'd0;
    else if (op == 8'h05 || op == 8'h2D || op == 8'h3D || op == 8'hC2) r = 2'd2;
    else if (op == 8'hA8 || op == 8'hCD || op == 8'hE5) r = 2'd1;
    return r;
  endfunction

  function automatic logic [5:0] grp5_op(input logic [2:0] reg_f);
    logic [5:0] r;
    case (reg_f)
      3'd0: r = 6'd13;
      3'd1: r = 6'd14;
      3'd2, 3'd3: r = 6'd48;
      3'd4, 3'd5: r = 6'd49;
      3'd6: r = 6'd15;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] op_number(input logic [7:0] op, input logic [7:0] m);
    logic [5:0] r;
    logic [2:0] rg;
    rg = m[5:3];
    if (alu_pair(op)) r = 6'd5 + {3'd0, op[5:3]};
    else if (in_rng(op, 8'h88, 8'h8B) || in_rng(op, 8'hB0, 8'hBF)) r = 6'd1;
    else if (in_rng(op, 8'h40, 8'h47)) r = 6'd13;
    else if (in_rng(op, 8'h48, 8'h4F)) r = 6'd14;
    else if (in_rng(op, 8'h50, 8'h57)) r = 6'd15;
    else if (in_rng(op, 8'h58, 8'h5F)) r = 6'd16;
    else if (in_rng(op, 8'h70, 8'h7F)) r = 6'd17 + {2'd0, op[3:0]};
    else if (in_rng(op, 8'h80, 8'h83)) r = 6'd5 + {3'd0, rg};
    else if (in_rng(op, 8'h91, 8'h97)) r = 6'd3;
    else begin
      case (op)
        8'h84, 8'h85, 8'hA8: r = 6'd4;
        8'h86, 8'h87: r = 6'd3;
        8'h8D: r = 6'd2;
        8'h90: r = 6'd33;
        8'hC6, 8'hC7, 8'hA3: r = 6'd1;
        8'hD1, 8'hD3: r = 6'd34 + {3'd0, rg};
        8'hF6, 8'hF7: r = (rg < 3'd2) ? 6'd4 : 6'd40 + {3'd0, rg};
        8'hFF: r = grp5_op(rg);
        8'h05: r = 6'd5;
        8'h2D: r = 6'd10;
        8'h3D: r = 6'd12;
        8'h98: r = 6'd50;
        8'h99: r = 6'd51;
        8'hA4: r = 6'd52;
        8'hA5: r = 6'd53;
        8'hAA: r = 6'd54;
        8'hAE: r = 6'd55;
        8'hC2, 8'hC3: r = 6'd56;
        8'hCD: r = 6'd57;
        8'hE2: r = 6'd58;
        8'hE5, 8'hEC: r = 6'd59;
        8'hE8: r = 6'd48;
        8'hE9, 8'hEB: r = 6'd49;
        8'hFC: r = 6'd60;
        8'hFD: r = 6'd61;
        default: r = 6'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [2:0] op_form(input logic [7:0] op, input logic [7:0] m);
    logic [2:0] r;
    if (alu_pair(op) || in_rng(op, 8'h88, 8'h8B)) r = op[1] ? 3'd1 : 3'd2;
    else if (op == OP_LEA) r = 3'd1;
    else if (in_rng(op, 8'h84, 8'h87) || op == 8'hA3) r = 3'd2;
    else if (is_relative(op)) r = 3'd6;
    else if (in_rng(op, 8'h80, 8'h83) || op == 8'hC6 || op == 8'hC7 || op == 8'hD1) r = 3'd4;
    else if (in_rng(op, 8'hB0, 8'hBF)) r = 3'd5;
    else if (op == 8'hF6 || op == 8'hF7) r = (m[5:3] < 3'd2) ? 3'd4 : 3'd3;
    else if (op == 8'hD3 || op == 8'hFF) r = 3'd3;
    else if (op == 8'h05 || op == 8'h2D || op == 8'h3D || op == 8'hA8 || op == 8'hE5)
      r = 3'd7;
    else r = 3'd0;
    return r;
  endfunction

  function automatic logic op_wide(input logic [7:0] op);
    logic r;
    if (alu_pair(op) || in_rng(op, 8'h84, 8'h8B)) r = op[0];
    else if (in_rng(op, 8'hB0, 8'hBF)) r = op[3];
    else if (op == 8'hC6 || op == 8'hC7 || op == 8'hF6 || op == 8'hF7) r = op[0];
    else if (in_rng(op, 8'h40, 8'h5F) || in_rng(op, 8'h90, 8'h97)) r = 1'b1;
    else begin
      case (op)
        8'h8D, 8'h81, 8'h83, 8'hD1, 8'hD3, 8'hFF, 8'h05, 8'h2D, 8'h3D, 8'hA3, 8'hA5,
        8'h99, 8'hC2, 8'hE5, 8'hE8, 8'hE9: r = 1'b1;
        default: r = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [2:0] op_reg(input logic [7:0] op, input logic [7:0] m);
    logic [2:0] r;
    if (wants_modrm(op)) r = m[5:3];
    else if (in_rng(op, 8'h40, 8'h5F) || in_rng(op, 8'h90, 8'h97) ||
             in_rng(op, 8'hB0, 8'hBF)) r = op[2:0];
    else r = 3'd0;
    return r;
  endfunction

endpackage

// ===== hw/rtl/x86d_collect.sv =====
module x86d_collect (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tlast,
  output logic                  q_wr,
  output x86d_pkg::raw_instr_t  q_wdata,
  input  logic                  q_full
);
  import x86d_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [AddrBits-1:0]  addr_r, addr_nxt;
  raw_instr_t           cur_r, cur_nxt;
  logic                 acc;

  assign in_tready = !q_full;
  assign acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      cur_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_comb begin
    raw_instr_t c;
    phase_t     nx;
    logic       done;
    logic [7:0] b;
    b = in_tdata;
    c = cur_r;
    nx = phase_r;
    done = 1'b0;
    if (phase_r == PH_IDLE) begin
      c = '0;
      c.start_addr = addr_r[15:0];
    end
    c.length = c.length + 3'd1;
    case (phase_r)
      PH_IDLE, PH_OPCODE: begin
        if (phase_r == PH_IDLE && (b == OP_REPNE || b == OP_REPE)) begin
          c.prefix_kind = (b == OP_REPNE) ? 2'd1 : 2'd2;
          nx = PH_OPCODE;
        end else begin
          c.opcode = b;
          if (wants_modrm(b)) nx = PH_MODRM;
          else if (disp_len(b, 8'd0) != 2'd0) nx = PH_DISP_LO;
          else if (imm_len(b, 8'd0) != 2'd0) nx = PH_IMM_LO;
          else done = 1'b1;
        end
      end
      PH_MODRM: begin
        c.modrm = b;
        if (disp_len(c.opcode, b) != 2'd0) nx = PH_DISP_LO;
        else if (imm_len(c.opcode, b) != 2'd0) nx = PH_IMM_LO;
        else done = 1'b1;
      end
      PH_DISP_LO: begin
        if (disp_len(c.opcode, c.modrm) == 2'd2) begin
          c.disp = {8'd0, b};
          nx = PH_DISP_HI;
        end else begin
          c.disp = {{8{b[7]}}, b};
          if (imm_len(c.opcode, c.modrm) != 2'd0) nx = PH_IMM_LO;
          else done = 1'b1;
        end
      end
      PH_DISP_HI: begin
        c.disp = {b, c.disp[7:0]};
        if (imm_len(c.opcode, c.modrm) != 2'd0) nx = PH_IMM_LO;
        else done = 1'b1;
      end
      PH_IMM_LO: begin
        if (imm_len(c.opcode, c.modrm) == 2'd2) begin
          c.imm = {8'd0, b};
          nx = PH_IMM_HI;
        end else begin
          c.imm = {((c.opcode == 8'h83) && b[7]) ? 8'hFF : 8'h00, b};
          done = 1'b1;
        end
      end
      PH_IMM_HI: begin
        c.imm = {b, c.imm[7:0]};
        done = 1'b1;
      end
      default: done = 1'b1;
    endcase
    c.trunc = !done;
    q_wdata = c;
    q_wr = acc && (done || in_tlast);
    phase_nxt = phase_r;
    cur_nxt = cur_r;
    addr_nxt = addr_r;
    if (acc) begin
      addr_nxt = addr_r + AddrBits'(1);
      cur_nxt = c;
      phase_nxt = (done || in_tlast) ? PH_IDLE : nx;
    end
  end

endmodule

// ===== hw/rtl/x86d_fifo.sv =====
module x86d_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr,
  input  x86d_pkg::raw_instr_t  wdata,
  output logic                  full,
  output logic                  rvalid,
  input  logic                  rd,
  output x86d_pkg::raw_instr_t  rdata
);
  import x86d_pkg::*;

  raw_instr_t  mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign full   = cnt_r == 2'd2;
  assign rvalid = cnt_r != 2'd0;
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== hw/rtl/x86d_decode.sv =====
module x86d_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_rd,
  input  x86d_pkg::raw_instr_t  q_rdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output x86d_pkg::dec_instr_t  out_item
);
  import x86d_pkg::*;

  logic        vld_r;
  dec_instr_t  res_r;
  dec_instr_t  res_nxt;

  assign q_rd = q_valid && (!vld_r || out_tready);
  assign out_tvalid = vld_r;
  assign out_item = res_r;

  always_comb begin
    raw_instr_t r;
    logic       t;
    r = q_rdata;
    t = r.trunc;
    res_nxt.start_addr    = r.start_addr;
    res_nxt.length        = r.length;
    res_nxt.operation     = t ? 6'd0 : op_number(r.opcode, r.modrm);
    res_nxt.prefix_kind   = r.prefix_kind;
    res_nxt.operand_form  = t ? 3'd0 : op_form(r.opcode, r.modrm);
    res_nxt.wide          = t ? 1'b0 : op_wide(r.opcode);
    res_nxt.reg_field     = t ? 3'd0 : op_reg(r.opcode, r.modrm);
    res_nxt.modrm_byte    = r.modrm;
    res_nxt.displacement  = r.disp;
    res_nxt.immediate     = (!t && r.opcode == 8'hD1) ? 16'd1 : r.imm;
    res_nxt.branch_target = (!t && is_relative(r.opcode)) ?
                            r.start_addr + {13'd0, r.length} + r.disp : 16'd0;
    res_nxt.status        = t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (q_rd) vld_r <= 1'b1;
    else if (out_tready) vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_rd) res_r <= res_nxt;
  end

endmodule

// ===== hw/rtl/x86_16bit_instruction_decoder.sv =====
// channel | tdata fields (lsb up)                               | tuser  | tlast
// in      | code_byte[7:0]                                      | -      | last_byte
// out     | start_addr, length, operation, prefix_kind,         | status | -
//         | operand_form, wide, reg_field, modrm_byte,          |        |
//         | displacement, immediate, branch_target (90b -> 96)  |        |
// One byte per cycle while in_tready is high; results are queued, then registered.
// Collector and decode register are parted by a two-entry queue.
// Reset is synchronous, active low; clears address, phase and queue.
// in_tready drops only while the queue is full behind a stalled output.
module x86_16bit_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // code_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // start_addr,length,operation,prefix_kind,operand_form,
                                  // wide,reg_field,modrm_byte,displacement,immediate,
                                  // branch_target
  output logic        out_tuser   // status
);
  import x86d_pkg::*;

  logic        q_wr, q_full, q_valid, q_rd;
  raw_instr_t  q_wdata, q_rdata;
  dec_instr_t  item;

  x86d_collect u_collect (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .q_wr, .q_wdata, .q_full
  );

  x86d_fifo u_fifo (
    .clk, .rst_n, .wr(q_wr), .wdata(q_wdata), .full(q_full),
    .rvalid(q_valid), .rd(q_rd), .rdata(q_rdata)
  );

  x86d_decode u_decode (
    .clk, .rst_n, .q_valid, .q_rd, .q_rdata, .out_tvalid, .out_tready,
    .out_item(item)
  );

  assign out_tdata = {6'd0, item.branch_target, item.immediate, item.displacement,
                      item.modrm_byte, item.reg_field, item.wide, item.operand_form,
                      item.prefix_kind, item.operation, item.length, item.start_addr};
  assign out_tuser = item.status;

endmodule

// ===== tb/x86d_checker.sv =====
module x86d_checker
  import x86d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic        out_tuser,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  dec_instr_t decoded_q[$];

  logic [15:0] pc;
  phase_t      ph;
  logic [1:0]  c_pfx;
  logic [7:0]  c_op;
  logic [7:0]  c_mrm;
  logic [15:0] c_disp;
  logic [15:0] c_imm;
  logic [15:0] c_start;
  logic [2:0]  c_len;

  assign pending = decoded_q.size();

  function automatic bit has_mrm(logic [7:0] op);
    return (op <= 8'h3F && !op[2]) || (op >= 8'h80 && op <= 8'h8B) || op == 8'h8D ||
           op == 8'hC6 || op == 8'hC7 || op == 8'hD1 || op == 8'hD3 ||
           op == 8'hF6 || op == 8'hF7 || op == 8'hFF;
  endfunction

  function automatic bit is_rel(logic [7:0] op);
    return (op >= 8'h70 && op <= 8'h7F) || op == 8'hE2 || op == 8'hE8 ||
           op == 8'hE9 || op == 8'hEB;
  endfunction

  function automatic int disp_bytes(logic [7:0] op, logic [7:0] m);
    if (has_mrm(op)) begin
      if (m[7:6] == 2'd0 && m[2:0] == 3'd6) return 2;
      if (m[7:6] == 2'd1) return 1;
      if (m[7:6] == 2'd2) return 2;
      return 0;
    end
    if ((op >= 8'h70 && op <= 8'h7F) || op == 8'hE2 || op == 8'hEB) return 1;
    if (op == 8'hE8 || op == 8'hE9 || op == 8'hA3) return 2;
    return 0;
  endfunction

  function automatic int imm_bytes(logic [7:0] op, logic [7:0] m);
    case (op)
      8'h80, 8'h82, 8'h83, 8'hC6, 8'hA8, 8'hCD, 8'hE5: return 1;
      8'h81, 8'hC7, 8'h05, 8'h2D, 8'h3D, 8'hC2: return 2;
      8'hF6: return (m[5:3] < 2) ? 1 : 0;
      8'hF7: return (m[5:3] < 2) ? 2 : 0;
      default: return (op >= 8'hB0 && op <= 8'hBF) ? (op[3] ? 2 : 1) : 0;
    endcase
  endfunction

  function automatic logic [5:0] mnemonic(logic [7:0] op, logic [7:0] m);
    logic [2:0] rg;
    rg = m[5:3];
    if (op <= 8'h3F && !op[2]) return 6'd5 + {3'd0, op[5:3]};
    if ((op >= 8'h88 && op <= 8'h8B) || (op >= 8'hB0 && op <= 8'hBF)) return 6'd1;
    if (op >= 8'h40 && op <= 8'h5F) return 6'd13 + {4'd0, op[4:3]};
    if (op >= 8'h70 && op <= 8'h7F) return 6'd17 + {2'd0, op[3:0]};
    if (op >= 8'h80 && op <= 8'h83) return 6'd5 + {3'd0, rg};
    if (op >= 8'h91 && op <= 8'h97) return 6'd3;
    case (op)
      8'h84, 8'h85, 8'hA8: return 6'd4;
      8'h86, 8'h87: return 6'd3;
      8'h8D: return 6'd2;
      8'h90: return 6'd33;
      8'hC6, 8'hC7, 8'hA3: return 6'd1;
      8'hD1, 8'hD3: return 6'd34 + {3'd0, rg};
      8'hF6, 8'hF7: return (rg < 3'd2) ? 6'd4 : 6'd40 + {3'd0, rg};
      8'hFF: begin
        case (rg)
          3'd0: return 6'd13;
          3'd1: return 6'd14;
          3'd2, 3'd3: return 6'd48;
          3'd4, 3'd5: return 6'd49;
          3'd6: return 6'd15;
          default: return 6'd0;
        endcase
      end
      8'h05: return 6'd5;
      8'h2D: return 6'd10;
      8'h3D: return 6'd12;
      8'h98: return 6'd50;
      8'h99: return 6'd51;
      8'hA4: return 6'd52;
      8'hA5: return 6'd53;
      8'hAA: return 6'd54;
      8'hAE: return 6'd55;
      8'hC2, 8'hC3: return 6'd56;
      8'hCD: return 6'd57;
      8'hE2: return 6'd58;
      8'hE5, 8'hEC: return 6'd59;
      8'hE8: return 6'd48;
      8'hE9, 8'hEB: return 6'd49;
      8'hFC: return 6'd60;
      8'hFD: return 6'd61;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [2:0] form_of(logic [7:0] op, logic [7:0] m);
    if ((op <= 8'h3F && !op[2]) || (op >= 8'h88 && op <= 8'h8B)) return op[1] ? 3'd1 : 3'd2;
    if (op == 8'h8D) return 3'd1;
    if ((op >= 8'h84 && op <= 8'h87) || op == 8'hA3) return 3'd2;
    if (is_rel(op)) return 3'd6;
    if ((op >= 8'h80 && op <= 8'h83) || op == 8'hC6 || op == 8'hC7 || op == 8'hD1)
      return 3'd4;
    if (op >= 8'hB0 && op <= 8'hBF) return 3'd5;
    if (op == 8'hF6 || op == 8'hF7) return (m[5:3] < 2) ? 3'd4 : 3'd3;
    if (op == 8'hD3 || op == 8'hFF) return 3'd3;
    if (op == 8'h05 || op == 8'h2D || op == 8'h3D || op == 8'hA8 || op == 8'hE5) return 3'd7;
    return 3'd0;
  endfunction

  function automatic logic word_sized(logic [7:0] op);
    if ((op <= 8'h3F && !op[2]) || (op >= 8'h84 && op <= 8'h8B)) return op[0];
    if (op >= 8'hB0 && op <= 8'hBF) return op[3];
    if (op == 8'hC6 || op == 8'hC7 || op == 8'hF6 || op == 8'hF7) return op[0];
    if ((op >= 8'h40 && op <= 8'h5F) || (op >= 8'h90 && op <= 8'h97)) return 1'b1;
    case (op)
      8'h8D, 8'h81, 8'h83, 8'hD1, 8'hD3, 8'hFF, 8'h05, 8'h2D, 8'h3D, 8'hA3, 8'hA5,
      8'h99, 8'hC2, 8'hE5, 8'hE8, 8'hE9: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [2:0] reg_of(logic [7:0] op, logic [7:0] m);
    if (has_mrm(op)) return m[5:3];
    if ((op >= 8'h40 && op <= 8'h5F) || (op >= 8'h90 && op <= 8'h97) ||
        (op >= 8'hB0 && op <= 8'hBF)) return op[2:0];
    return 3'd0;
  endfunction

  function automatic dec_instr_t decoded(bit cut);
    dec_instr_t d;
    d = '0;
    d.start_addr   = c_start;
    d.length       = c_len;
    d.prefix_kind  = c_pfx;
    d.modrm_byte   = c_mrm;
    d.displacement = c_disp;
    d.immediate    = c_imm;
    d.status       = cut;
    if (!cut) begin
      d.operation    = mnemonic(c_op, c_mrm);
      d.operand_form = form_of(c_op, c_mrm);
      d.wide         = word_sized(c_op);
      d.reg_field    = reg_of(c_op, c_mrm);
      if (c_op == 8'hD1) d.immediate = 16'd1;
      if (is_rel(c_op)) d.branch_target = c_start + {13'd0, c_len} + c_disp;
    end
    return d;
  endfunction

  function automatic phase_t after_disp_ph();
    return (imm_bytes(c_op, c_mrm) != 0) ? PH_IMM_LO : PH_IDLE;
  endfunction

  function automatic phase_t after_head_ph();
    return (disp_bytes(c_op, c_mrm) != 0) ? PH_DISP_LO : after_disp_ph();
  endfunction

  task automatic take_byte(logic [7:0] b, logic last);
    phase_t nxt;
    if (ph == PH_IDLE) begin
      c_start = pc;
      c_len   = 3'd0;
      c_pfx   = 2'd0;
      c_op    = 8'h00;
      c_mrm   = 8'h00;
      c_disp  = 16'h0;
      c_imm   = 16'h0;
    end
    pc    = pc + 16'd1;
    c_len = c_len + 3'd1;
    case (ph)
      PH_IDLE, PH_OPCODE: begin
        if (ph == PH_IDLE && (b == OP_REPNE || b == OP_REPE)) begin
          c_pfx = (b == OP_REPNE) ? 2'd1 : 2'd2;
          nxt   = PH_OPCODE;
        end else begin
          c_op = b;
          nxt  = has_mrm(b) ? PH_MODRM : after_head_ph();
        end
      end
      PH_MODRM: begin
        c_mrm = b;
        nxt   = after_head_ph();
      end
      PH_DISP_LO: begin
        if (disp_bytes(c_op, c_mrm) == 2) begin
          c_disp = {8'h00, b};
          nxt    = PH_DISP_HI;
        end else begin
          c_disp = {{8{b[7]}}, b};
          nxt    = after_disp_ph();
        end
      end
      PH_DISP_HI: begin
        c_disp[15:8] = b;
        nxt          = after_disp_ph();
      end
      PH_IMM_LO: begin
        c_imm = {8'h00, b};
        if (imm_bytes(c_op, c_mrm) == 2) nxt = PH_IMM_HI;
        else begin
          if (c_op == 8'h83) c_imm[15:8] = {8{b[7]}};
          nxt = PH_IDLE;
        end
      end
      default: begin
        c_imm[15:8] = b;
        nxt         = PH_IDLE;
      end
    endcase
    if (nxt == PH_IDLE) begin
      decoded_q.push_back(decoded(1'b0));
      ph = PH_IDLE;
    end else if (last) begin
      decoded_q.push_back(decoded(1'b1));
      ph = PH_IDLE;
    end else begin
      ph = nxt;
    end
  endtask

  task automatic check_result();
    dec_instr_t e;
    logic [95:0] v;
    v = out_tdata;
    if (decoded_q.size() == 0) begin
      $error("unexpected result transaction");
      errors++;
      return;
    end
    e = decoded_q.pop_front();
    if (v[15:0] !== e.start_addr) begin
      $error("start_addr exp %h got %h", e.start_addr, v[15:0]); errors++;
    end
    if (v[18:16] !== e.length) begin
      $error("length exp %0d got %0d", e.length, v[18:16]); errors++;
    end
    if (v[24:19] !== e.operation) begin
      $error("operation exp %0d got %0d", e.operation, v[24:19]); errors++;
    end
    if (v[26:25] !== e.prefix_kind) begin
      $error("prefix_kind exp %0d got %0d", e.prefix_kind, v[26:25]); errors++;
    end
    if (v[29:27] !== e.operand_form) begin
      $error("operand_form exp %0d got %0d", e.operand_form, v[29:27]); errors++;
    end
    if (v[30] !== e.wide) begin
      $error("wide exp %b got %b", e.wide, v[30]); errors++;
    end
    if (v[33:31] !== e.reg_field) begin
      $error("reg_field exp %0d got %0d", e.reg_field, v[33:31]); errors++;
    end
    if (v[41:34] !== e.modrm_byte) begin
      $error("modrm_byte exp %h got %h", e.modrm_byte, v[41:34]); errors++;
    end
    if (v[57:42] !== e.displacement) begin
      $error("displacement exp %h got %h", e.displacement, v[57:42]); errors++;
    end
    if (v[73:58] !== e.immediate) begin
      $error("immediate exp %h got %h", e.immediate, v[73:58]); errors++;
    end
    if (v[89:74] !== e.branch_target) begin
      $error("branch_target exp %h got %h", e.branch_target, v[89:74]); errors++;
    end
    if (out_tuser !== e.status) begin
      $error("status exp %b got %b", e.status, out_tuser); errors++;
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      pc = 16'h0;
      ph = PH_IDLE;
      decoded_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
    end
  end
endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  int          errors;
  int          pending;
  int          send_idle_pct = 33;
  int          recv_idle_pct = 82;
  longint      cycles = 0;

  logic [7:0] known_ops[] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h38, 8'h3B, 8'h05, 8'h2D, 8'h3D, 8'h40, 8'h4F,
    8'h50, 8'h5F, 8'h70, 8'h74, 8'h7F, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h87,
    8'h88, 8'h8B, 8'h8D, 8'h90, 8'h93, 8'h98, 8'h99, 8'hA3, 8'hA4, 8'hA5, 8'hA8,
    8'hAA, 8'hAE, 8'hB0, 8'hB7, 8'hB8, 8'hBF, 8'hC2, 8'hC3, 8'hC6, 8'hC7, 8'hCD,
    8'hD1, 8'hD3, 8'hE2, 8'hE5, 8'hE8, 8'hE9, 8'hEB, 8'hEC, 8'hF2, 8'hF3, 8'hF6,
    8'hF7, 8'hFC, 8'hFD, 8'hFF
  };

  logic [7:0] directed[] = '{
    8'h00, 8'hC0, 8'h81, 8'h06, 8'h34, 8'h12, 8'h78, 8'h56, 8'h83, 8'h40, 8'hFF,
    8'h80, 8'hF3, 8'hF2, 8'hD1, 8'hE0, 8'hD3, 8'hE8, 8'hF7, 8'hC0, 8'hFF, 8'hFF,
    8'hFF, 8'hF8, 8'hF3, 8'hE8, 8'h00, 8'h80, 8'h82, 8'hC0, 8'h7F, 8'hCD, 8'h21,
    8'hA3, 8'hFF, 8'hFF, 8'hC2, 8'h00, 8'h00, 8'h75, 8'h80, 8'hB8, 8'h55, 8'hAA
  };

  x86_16bit_instruction_decoder dut (.*);

  x86d_checker chk (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_byte(directed[i], 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h12, 1'b1);
    send_byte(8'hF3, 1'b1);
    send_byte(8'h90, 1'b1);
    drain();
    for (int i = 0; i < 1250; i++) begin
      if (i == 420) begin
        send_idle_pct = 82;
        recv_idle_pct = 33;
      end else if (i == 840) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 600) drain();
      if ($urandom_range(99) < 60)
        send_byte(known_ops[$urandom_range(known_ops.size() - 1)], $urandom_range(99) < 3);
      else
        send_byte(8'($urandom), $urandom_range(99) < 3);
    end
    send_byte(8'($urandom), 1'b1);
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
